// ===== src/cpmt_pkg.sv =====
package cpmt_pkg;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_SCAN   = 3'd2,
    MODE_POP    = 3'd3,
    MODE_QUERY  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TBL_FULL  = 2'd1,
    ST_RING_FULL = 2'd2,
    ST_RING_EMPT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_INSERT,
    S_HEAD,
    S_WALK_RD,
    S_WALK_CMP,
    S_MARK,
    S_POP_RD,
    S_QRY_RD,
    S_RESULT,
    S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clr_start;
    logic clr_step;
    logic do_insert;
    logic head_rd;
    logic walk_rd;
    logic walk_cmp;
    logic do_mark;
    logic pop_rd;
    logic qry_rd;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_done;
    logic       tbl_full;
    logic       na_zero;
    logic       chain_end;
    logic       match;
    logic       ring_empty;
    logic       qry_valid;
  } stat_t;

endpackage

// ===== src/cpmt_ctrl.sv =====
module cpmt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  logic [2:0]     in_mode_i,
  input  logic           out_taken_i,
  input  cpmt_pkg::stat_t stat_i,
  output cpmt_pkg::cmd_t  cmd_o,
  output logic           in_ready_o,
  output logic           out_valid_o
);
  import cpmt_pkg::*;

  state_e state_q, state_d;
  logic [2:0] mode_q;

  // mode register, any non-clear code so the power-up sweep returns to idle silently
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      mode_q  <= MODE_SCAN;
    end else begin
      state_q <= state_d;
      if (in_fire_i) mode_q <= in_mode_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          case (in_mode_i)
            MODE_CLEAR:  state_d = S_CLEAR;
            MODE_INSERT: state_d = S_INSERT;
            MODE_SCAN:   state_d = S_HEAD;
            MODE_POP:    state_d = S_POP_RD;
            MODE_QUERY:  state_d = S_QRY_RD;
            default:     state_d = S_RESULT;
          endcase
        end
      end
      S_CLEAR:    if (stat_i.clr_done) state_d = (mode_q == MODE_CLEAR) ? S_RESULT : S_IDLE;
      S_INSERT:   state_d = S_RESULT;
      S_HEAD:     state_d = stat_i.na_zero ? S_RESULT : S_WALK_RD;
      S_WALK_RD:  state_d = stat_i.chain_end ? S_RESULT : S_WALK_CMP;
      S_WALK_CMP: state_d = stat_i.match ? S_MARK : S_WALK_RD;
      S_MARK:     state_d = S_RESULT;
      S_POP_RD:   state_d = S_RESULT;
      S_QRY_RD:   state_d = S_RESULT;
      S_RESULT:   state_d = S_OUT;
      S_OUT:      if (out_taken_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.capture = in_fire_i;
        cmd_o.clr_start = in_fire_i && (in_mode_i == MODE_CLEAR);
      end
      S_CLEAR:    cmd_o.clr_step = 1'b1;
      S_INSERT:   cmd_o.do_insert = 1'b1;
      S_HEAD:     cmd_o.head_rd = 1'b1;
      S_WALK_RD:  cmd_o.walk_rd = 1'b1;
      S_WALK_CMP: cmd_o.walk_cmp = 1'b1;
      S_MARK:     cmd_o.do_mark = 1'b1;
      S_POP_RD:   cmd_o.pop_rd = 1'b1;
      S_QRY_RD:   cmd_o.qry_rd = 1'b1;
      S_RESULT:   cmd_o.load_out = 1'b1;
      S_OUT:      out_valid_o = 1'b1;
      default:    ;
    endcase
  end

endmodule

// ===== src/cpmt_dp.sv =====
module cpmt_dp #(
  parameter int MAX_ENTRIES   = 1024,
  parameter int BUCKETS       = 256,
  parameter int RING_DEPTH    = 1024,
  parameter int POINTER_ALIGN = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cpmt_pkg::cmd_t  cmd_i,
  output cpmt_pkg::stat_t stat_o,
  input  logic [7:0]      header_i,
  input  logic [2:0]      mode_i,
  input  logic [31:0]     node_i,
  input  logic [31:0]     size_i,
  input  logic [31:0]     word_i,
  input  logic [9:0]      query_i,
  output logic [1:0]      status_o,
  output logic            hit_o,
  output logic [9:0]      bnum_o,
  output logic [31:0]     uaddr_o,
  output logic [31:0]     bytes_o,
  output logic            reach_o
);
  import cpmt_pkg::*;

  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int LW = $clog2(MAX_ENTRIES + 1);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW = $clog2(RING_DEPTH);
  localparam int AW = (POINTER_ALIGN > 1) ? $clog2(POINTER_ALIGN) : 1;
  localparam logic [LW-1:0] NIL = LW'(MAX_ENTRIES);

  // memories
  logic [31:0]   node_mem [MAX_ENTRIES];
  logic [31:0]   size_mem [MAX_ENTRIES];
  logic          mark_mem [MAX_ENTRIES];
  logic          qd_mem   [MAX_ENTRIES];
  logic [LW-1:0] link_mem [MAX_ENTRIES];
  logic [LW-1:0] head_mem [BUCKETS];
  logic [EW-1:0] ring_mem [RING_DEPTH];

  // captured item
  logic [2:0]  mode_q;
  logic [31:0] a_q, b_q;
  logic [9:0]  qry_q;
  logic [LW-1:0] count_q;
  logic [RW-1:0] rhead_q, rtail_q;
  logic [BW:0]   clr_q;
  logic [LW-1:0] cur_q, link_q;
  logic [31:0]   nd_q, sz_q;
  logic          mk_q, qb_q;
  logic [EW-1:0] ring_rd_q;
  logic [1:0]  st_q;
  logic        hit_q;
  logic [9:0]  bn_q;

  logic [31:0] na;
  logic [BW-1:0] bkt;
  logic [32:0] endv;
  logic        aligned, match;
  logic [RW-1:0] tail_nx;

  assign na = word_i - {24'd0, header_i};
  function automatic logic [BW-1:0] bucket_f(input logic [31:0] x);
    logic [31:0] s;
    s = x >> 4;
    bucket_f = BW'(s % BUCKETS);
  endfunction
  assign bkt = bucket_f(cmd_i.capture ? (mode_i == MODE_SCAN ? na : node_i)
                                      : a_q);
  assign endv = {1'b0, nd_q} + {1'b0, sz_q};
  assign aligned = (POINTER_ALIGN <= 1) || (a_q[AW-1:0] == '0);
  assign match = (a_q == nd_q) ||
                 (aligned && ({1'b0, a_q} > {1'b0, nd_q}) && ({1'b0, a_q} < endv));
  assign tail_nx = (rtail_q == RW'(RING_DEPTH - 1)) ? '0 : rtail_q + 1'b1;

  assign stat_o.clr_done   = (clr_q == (BW+1)'(BUCKETS - 1)) || (clr_q >= (BW+1)'(BUCKETS));
  assign stat_o.tbl_full   = count_q >= NIL;
  assign stat_o.na_zero    = (a_q == '0);
  assign stat_o.chain_end  = (link_q >= NIL);
  assign stat_o.match      = match;
  assign stat_o.ring_empty = (rhead_q == rtail_q);
  assign stat_o.qry_valid  = ({{(32-LW){1'b0}}, count_q} > {22'd0, qry_q}) &&
                             (32'(qry_q) < 32'(MAX_ENTRIES));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rhead_q <= '0;
      rtail_q <= '0;
      clr_q   <= '0;
    end else begin
      if (cmd_i.clr_start) begin
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
        count_q <= '0;
        rhead_q <= '0;
        rtail_q <= '0;
      end
      if (cmd_i.do_insert && !stat_o.tbl_full) count_q <= count_q + 1'b1;
      if (cmd_i.do_mark && !qb_q && (32'(cur_q) < 32'(count_q)) && tail_nx != rhead_q)
        rtail_q <= tail_nx;
      if (cmd_i.pop_rd && !stat_o.ring_empty)
        rhead_q <= (rhead_q == RW'(RING_DEPTH - 1)) ? '0 : rhead_q + 1'b1;
    end
  end

  // bucket heads, read at capture so an insert links to the current head
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) head_mem[clr_q[BW-1:0]] <= NIL;
    else if (cmd_i.do_insert && !stat_o.tbl_full) head_mem[bkt] <= count_q;
    if (cmd_i.head_rd || cmd_i.capture) link_q <= head_mem[bkt];
    else if (cmd_i.walk_cmp) link_q <= link_mem[cur_q[EW-1:0]];
  end

  // entry tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      a_q    <= (mode_i == MODE_SCAN) ? na : node_i;
      b_q    <= size_i;
      qry_q  <= query_i;
    end
    if (cmd_i.do_insert && !stat_o.tbl_full) begin
      node_mem[count_q[EW-1:0]] <= a_q;
      size_mem[count_q[EW-1:0]] <= b_q;
      link_mem[count_q[EW-1:0]] <= link_q;
    end
    if (cmd_i.walk_rd) begin
      cur_q <= link_q;
      nd_q  <= node_mem[link_q[EW-1:0]];
      sz_q  <= size_mem[link_q[EW-1:0]];
    end else if (cmd_i.pop_rd) begin
      nd_q <= node_mem[ring_rd_q];
      sz_q <= size_mem[ring_rd_q];
      mk_q <= mark_mem[ring_rd_q];
      cur_q <= LW'(ring_rd_q);
    end else if (cmd_i.qry_rd) begin
      nd_q <= node_mem[qry_q[EW-1:0]];
      sz_q <= size_mem[qry_q[EW-1:0]];
      mk_q <= mark_mem[qry_q[EW-1:0]];
    end
  end

  // mark, queued bits and ring
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_insert && !stat_o.tbl_full) begin
      mark_mem[count_q[EW-1:0]] <= 1'b0;
      qd_mem[count_q[EW-1:0]]   <= 1'b0;
    end else if (cmd_i.do_mark && (32'(cur_q) < 32'(count_q))) begin
      mark_mem[cur_q[EW-1:0]] <= 1'b1;
      qd_mem[cur_q[EW-1:0]]   <= 1'b1;
    end
    if (cmd_i.walk_cmp) qb_q <= qd_mem[cur_q[EW-1:0]];
    if (cmd_i.do_mark && !qb_q && (32'(cur_q) < 32'(count_q)) && tail_nx != rhead_q)
      ring_mem[rtail_q] <= cur_q[EW-1:0];
    ring_rd_q <= ring_mem[rhead_q];
  end

  // result fields gathered per mode
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      st_q <= ST_OK;
      hit_q <= 1'b0;
      bn_q <= '0;
    end
    if (cmd_i.do_insert) begin
      if (stat_o.tbl_full) st_q <= ST_TBL_FULL;
      else bn_q <= 10'(count_q);
    end
    if (cmd_i.do_mark) begin
      hit_q <= 1'b1;
      bn_q <= 10'(cur_q);
      if (!qb_q && (32'(cur_q) < 32'(count_q)) && tail_nx == rhead_q) st_q <= ST_RING_FULL;
    end
    if (cmd_i.pop_rd) begin
      if (stat_o.ring_empty) st_q <= ST_RING_EMPT;
    end
    if (cmd_i.load_out) begin
      status_o <= st_q;
      hit_o    <= hit_q;
      bnum_o   <= bn_q;
      uaddr_o  <= '0;
      bytes_o  <= '0;
      reach_o  <= hit_q;
      if (mode_q == MODE_POP && st_q == ST_OK) begin
        bnum_o  <= 10'(cur_q);
        uaddr_o <= nd_q + {24'd0, header_i};
        bytes_o <= sz_q;
        reach_o <= mk_q;
      end else if (mode_q == MODE_QUERY) begin
        bnum_o <= qry_q;
        if (stat_o.qry_valid) begin
          uaddr_o <= nd_q + {24'd0, header_i};
          bytes_o <= sz_q;
          reach_o <= mk_q;
        end
      end
    end
  end

endmodule

// ===== src/conservative_pointer_mark_table.sv =====
// Mark table for a conservative mark-and-sweep collector. Items select clear, insert,
// scan, pop or query by tuser mode; each gives one result. A scan reads the bucket
// head and then visits the bucket chain, each entry visited being one read of the
// node/size tables and one compare; when the word equals the header no chain entry is
// visited. Clear sweeps the BUCKETS bucket heads one per cycle, and the same sweep
// runs after reset before the first item is taken. One item is in flight at a time.
module conservative_pointer_mark_table #(
  parameter int MAX_ENTRIES   = 1024,
  parameter int BUCKETS       = 256,
  parameter int RING_DEPTH    = 1024,
  parameter int POINTER_ALIGN = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // node_address[31:0], usable_size[63:32], scanned_word[95:64], query_index[105:96]
  input  logic [111:0] s_axis_tdata,
  // mode[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], hit[2], block_number[12:3], user_address[44:13], block_bytes[76:45],
  // is_reachable[77]
  output logic [79:0]  m_axis_tdata
);
  import cpmt_pkg::*;

  logic [7:0] header_q;
  cmd_t  cmd;
  stat_t stat;
  logic [1:0] st;
  logic hit, reach;
  logic [9:0] bn;
  logic [31:0] ua, by;

  // header register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) header_q <= 8'd16;
    else if (cfg_we_i) header_q <= cfg_wdata_i;
  end

  cpmt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid && s_axis_tready),
    .in_mode_i(s_axis_tuser),
    .out_taken_i(m_axis_tready),
    .stat_i(stat), .cmd_o(cmd),
    .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid)
  );

  cpmt_dp #(
    .MAX_ENTRIES(MAX_ENTRIES), .BUCKETS(BUCKETS),
    .RING_DEPTH(RING_DEPTH), .POINTER_ALIGN(POINTER_ALIGN)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .header_i(header_q),
    .mode_i(s_axis_tuser), .node_i(s_axis_tdata[31:0]), .size_i(s_axis_tdata[63:32]),
    .word_i(s_axis_tdata[95:64]), .query_i(s_axis_tdata[105:96]),
    .status_o(st), .hit_o(hit), .bnum_o(bn), .uaddr_o(ua), .bytes_o(by), .reach_o(reach)
  );

  assign m_axis_tdata = {2'b00, reach, by, ua, bn, hit, st};

endmodule

// ===== tb/tb_conservative_pointer_mark_table.sv =====
module tb_conservative_pointer_mark_table;
  timeunit 1ns;
  timeprecision 1ps;

  import cpmt_pkg::*;

  localparam int NUM_BLOCKS  = 1024;
  localparam int NUM_BUCKETS = 256;
  localparam int RING_SLOTS  = 1024;
  localparam int PTR_ALIGN   = 4;
  localparam int NIL         = NUM_BLOCKS;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 40;

  // unused mode codes, the block leaves its tables alone and answers with a zero result
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [9:0]  block_number;
    logic [31:0] user_address;
    logic [31:0] block_bytes;
    logic        is_reachable;
  } mark_result_t;

  typedef struct {
    logic [2:0]   mode;
    logic [31:0]  node;
    logic [31:0]  size;
    logic [31:0]  word;
    logic [9:0]   query;
    bit           typed;
    mark_result_t res;
  } stim_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [7:0]   cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [79:0]  m_axis_tdata;

  conservative_pointer_mark_table i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // shadow of the mark table
  logic [31:0] hdr_bytes;
  logic [31:0] node_mem [NUM_BLOCKS];
  logic [31:0] size_mem [NUM_BLOCKS];
  bit          mark_mem [NUM_BLOCKS];
  bit          queued_mem [NUM_BLOCKS];
  int          link_mem [NUM_BLOCKS];
  int          bucket_head [NUM_BUCKETS];
  int          ring_mem [RING_SLOTS];
  int          ring_rd;
  int          ring_wr;
  int          blk_count;

  mark_result_t expected_q[$];
  int           fail_count;
  int           cycle_count;
  bit           quiet;
  bit           hold_long;

  function automatic void table_empty();
    for (int b = 0; b < NUM_BUCKETS; b++) bucket_head[b] = NIL;
    blk_count = 0;
    ring_rd   = 0;
    ring_wr   = 0;
  endfunction

  function automatic int bucket_sel(logic [31:0] addr);
    return int'((addr >> 4) % NUM_BUCKETS);
  endfunction

  function automatic int chain_lookup(logic [31:0] addr);
    int e;
    int steps;
    logic [32:0] lo;
    logic [32:0] hi;
    e = bucket_head[bucket_sel(addr)];
    steps = 0;
    while (e < NUM_BLOCKS && steps < NUM_BLOCKS) begin
      lo = {1'b0, node_mem[e]};
      hi = lo + {1'b0, size_mem[e]};
      if ({1'b0, addr} == lo) return e;
      if ((addr % PTR_ALIGN) == 0 && {1'b0, addr} > lo && {1'b0, addr} < hi) return e;
      e = link_mem[e];
      steps++;
    end
    return NIL;
  endfunction

  // returns 1 when the worklist push is dropped
  function automatic bit mark_block(int idx);
    if (idx >= blk_count) return 0;
    mark_mem[idx] = 1;
    if (queued_mem[idx]) return 0;
    queued_mem[idx] = 1;
    if ((ring_wr + 1) % RING_SLOTS == ring_rd) return 1;
    ring_mem[ring_wr] = idx;
    ring_wr = (ring_wr + 1) % RING_SLOTS;
    return 0;
  endfunction

  function automatic mark_result_t mark_predict(logic [2:0] mode, logic [31:0] node,
                                                logic [31:0] size, logic [31:0] word,
                                                logic [9:0] query);
    mark_result_t r;
    logic [31:0] na;
    int idx;
    int b;
    r = '0;
    case (mode)
      MODE_CLEAR: table_empty();
      MODE_INSERT: begin
        if (blk_count >= NUM_BLOCKS) begin
          r.status = ST_TBL_FULL;
        end else begin
          idx = blk_count;
          b = bucket_sel(node);
          node_mem[idx]   = node;
          size_mem[idx]   = size;
          mark_mem[idx]   = 0;
          queued_mem[idx] = 0;
          link_mem[idx]   = bucket_head[b];
          bucket_head[b]  = idx;
          blk_count       = idx + 1;
          r.block_number  = idx[9:0];
        end
      end
      MODE_SCAN: begin
        na = word - hdr_bytes;
        if (na != 0) begin
          idx = chain_lookup(na);
          if (idx < NUM_BLOCKS) begin
            r.hit = 1;
            r.block_number = idx[9:0];
            r.is_reachable = 1;
            if (mark_block(idx)) r.status = ST_RING_FULL;
          end
        end
      end
      MODE_POP: begin
        if (ring_rd == ring_wr) begin
          r.status = ST_RING_EMPT;
        end else begin
          idx = ring_mem[ring_rd];
          ring_rd = (ring_rd + 1) % RING_SLOTS;
          r.block_number = idx[9:0];
          r.user_address = node_mem[idx] + hdr_bytes;
          r.block_bytes  = size_mem[idx];
          r.is_reachable = mark_mem[idx];
        end
      end
      MODE_QUERY: begin
        r.block_number = query;
        if (int'(query) < blk_count) begin
          r.user_address = node_mem[query] + hdr_bytes;
          r.block_bytes  = size_mem[query];
          r.is_reachable = mark_mem[query];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stim_row_t mk_row(logic [2:0] mode, logic [31:0] node, logic [31:0] size,
                                       logic [31:0] word, logic [9:0] query, bit typed,
                                       mark_result_t res);
    stim_row_t s;
    s.mode = mode; s.node = node; s.size = size; s.word = word; s.query = query;
    s.typed = typed; s.res = res;
    return s;
  endfunction

  function automatic mark_result_t mk_res(logic [1:0] st, logic h, logic [9:0] bn,
                                          logic [31:0] ua, logic [31:0] by, logic rc);
    mark_result_t r;
    r.status = st; r.hit = h; r.block_number = bn;
    r.user_address = ua; r.block_bytes = by; r.is_reachable = rc;
    return r;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    mark_result_t got;
    mark_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status       = m_axis_tdata[1:0];
      got.hit          = m_axis_tdata[2];
      got.block_number = m_axis_tdata[12:3];
      got.user_address = m_axis_tdata[44:13];
      got.block_bytes  = m_axis_tdata[76:45];
      got.is_reachable = m_axis_tdata[77];
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $write("mismatch: exp st=%0d hit=%0d bn=%0d ua=%h by=%h rc=%0d",
                   want.status, want.hit, want.block_number, want.user_address,
                   want.block_bytes, want.is_reachable);
            $display(" / got st=%0d hit=%0d bn=%0d ua=%h by=%h rc=%0d",
                     got.status, got.hit, got.block_number, got.user_address,
                     got.block_bytes, got.is_reachable);
          end
        end
      end
    end
  end

  // offer one input transaction and record its expectation on acceptance
  task automatic send_item(logic [2:0] mode, logic [31:0] node, logic [31:0] size,
                           logic [31:0] word, logic [9:0] query, bit typed,
                           mark_result_t res);
    mark_result_t pred;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {6'b0, query, word, size, node};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = mark_predict(mode, node, size, word, query);
    expected_q.push_back(typed ? res : pred);
    @(negedge clk_i);
  endtask

  task automatic idle_wait();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_header(logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    hdr_bytes   = {24'b0, val};
    @(negedge clk_i);
  endtask

  // one random transaction, many of them pointers into registered blocks
  task automatic random_item();
    int          pick;
    int          i;
    logic [31:0] node;
    logic [31:0] size;
    logic [31:0] word;
    logic [31:0] off;
    logic [9:0]  query;
    logic [2:0]  mode;
    pick  = $urandom_range(0, 99);
    node  = $urandom;
    size  = $urandom;
    word  = $urandom;
    query = 10'($urandom);
    if (pick < 14) begin
      mode = MODE_INSERT;
      if ($urandom_range(0, 1)) node = 32'h4000_0000 + ($urandom_range(0, 1023) << 2);
      case ($urandom_range(0, 9))
        0: size = 32'h0;
        1: size = 32'hFFFF_FFFF;
        2, 3: ;
        default: size = $urandom_range(0, 512);
      endcase
    end else if (pick < 55 && blk_count > 0) begin
      mode = MODE_SCAN;
      i = $urandom_range(0, blk_count - 1);
      off = 0;
      if (size_mem[i] != 0 && $urandom_range(0, 2) != 0)
        off = $urandom_range(0, size_mem[i] > 600 ? 600 : size_mem[i] - 1);
      if ($urandom_range(0, 3) != 0) off = off & ~32'(PTR_ALIGN - 1);
      word = node_mem[i] + off + hdr_bytes;
    end else if (pick < 65) begin
      mode = MODE_SCAN;
      if ($urandom_range(0, 7) == 0) word = hdr_bytes;
    end else if (pick < 78) begin
      mode = MODE_POP;
    end else if (pick < 91) begin
      mode = MODE_QUERY;
      if ($urandom_range(0, 3) != 0) query = 10'($urandom_range(0, blk_count + 2));
    end else if (pick < 94) begin
      mode = MODE_CLEAR;
    end else if (pick < 97) begin
      case ($urandom_range(0, 2))
        0: mode = MODE_RSVD5;
        1: mode = MODE_RSVD6;
        default: mode = MODE_RSVD7;
      endcase
    end else begin
      mode = MODE_INSERT;
    end
    send_item(mode, node, size, word, query, 0, '0);
  endtask

  initial begin
    stim_row_t   rows[$];
    logic [7:0]  hdr_set[5];
    hdr_set = '{8'd0, 8'd255, 8'd8, 8'd16, 8'd0};
    hdr_set[2] = 8'($urandom);
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    fail_count    = 0;
    quiet         = 0;
    hold_long     = 0;
    hdr_bytes     = 32'd16;
    table_empty();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // bucket sweep after reset
    repeat (NUM_BUCKETS + SETTLE) @(negedge clk_i);

    // directed part, header of 16 from reset
    rows.push_back(mk_row(MODE_POP,    0, 0, 0, 0, 1, mk_res(ST_RING_EMPT, 0, 0, 0, 0, 0)));
    rows.push_back(mk_row(MODE_QUERY,  0, 0, 0, 5, 1, mk_res(ST_OK, 0, 5, 0, 0, 0)));
    rows.push_back(mk_row(MODE_SCAN,   0, 0, 32'd16, 0, 1, '0));
    rows.push_back(mk_row(MODE_INSERT, 32'h100, 32'h40, 0, 0, 1, mk_res(ST_OK, 0, 0, 0, 0, 0)));
    rows.push_back(mk_row(MODE_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0, 0, 1,
                          mk_res(ST_OK, 0, 1, 0, 0, 0)));
    rows.push_back(mk_row(MODE_INSERT, 0, 0, 0, 0, 1, mk_res(ST_OK, 0, 2, 0, 0, 0)));
    rows.push_back(mk_row(MODE_SCAN,   0, 0, 32'h110, 0, 1, mk_res(ST_OK, 1, 0, 0, 0, 1)));
    rows.push_back(mk_row(MODE_SCAN,   0, 0, 32'h110, 0, 0, '0));
    rows.push_back(mk_row(MODE_SCAN,   0, 0, 32'h124, 0, 0, '0));
    rows.push_back(mk_row(MODE_SCAN,   0, 0, 32'h125, 0, 0, '0));
    rows.push_back(mk_row(MODE_SCAN,   0, 0, 32'h150, 0, 0, '0));
    rows.push_back(mk_row(MODE_SCAN,   0, 0, 32'h0000_000C, 0, 0, '0));
    rows.push_back(mk_row(MODE_SCAN,   0, 0, 32'hFFFF_FFFF, 0, 0, '0));
    rows.push_back(mk_row(MODE_POP,    0, 0, 0, 0, 1,
                          mk_res(ST_OK, 0, 0, 32'h110, 32'h40, 1)));
    rows.push_back(mk_row(MODE_POP,    0, 0, 0, 0, 0, '0));
    rows.push_back(mk_row(MODE_POP,    0, 0, 0, 0, 1, mk_res(ST_RING_EMPT, 0, 0, 0, 0, 0)));
    rows.push_back(mk_row(MODE_QUERY,  0, 0, 0, 2, 1, mk_res(ST_OK, 0, 2, 32'd16, 0, 0)));
    rows.push_back(mk_row(MODE_QUERY,  0, 0, 0, 10'h3FF, 1,
                          mk_res(ST_OK, 0, 10'h3FF, 0, 0, 0)));
    rows.push_back(mk_row(MODE_RSVD5,  '1, '1, '1, '1, 1, '0));
    rows.push_back(mk_row(MODE_RSVD6,  '1, '1, '1, '1, 1, '0));
    rows.push_back(mk_row(MODE_RSVD7,  '1, '1, '1, '1, 1, '0));
    rows.push_back(mk_row(MODE_CLEAR,  '1, '1, '1, '1, 1, '0));
    rows.push_back(mk_row(MODE_QUERY,  0, 0, 0, 0, 1, mk_res(ST_OK, 0, 0, 0, 0, 0)));
    rows.push_back(mk_row(MODE_SCAN,   0, 0, 32'h110, 0, 1, '0));
    foreach (rows[k])
      send_item(rows[k].mode, rows[k].node, rows[k].size, rows[k].word, rows[k].query,
                rows[k].typed, rows[k].res);

    // random phases over several header sizes
    for (int p = 0; p < 5; p++) begin
      idle_wait();
      write_header(hdr_set[p]);
      if (p == 1) hold_long = 1;
      for (int n = 0; n < 140; n++) random_item();
    end

    // last phase, no idling
    idle_wait();
    quiet = 1;
    write_header(8'd16);
    for (int n = 0; n < 126; n++) random_item();

    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
